[hw/rtl/aabbtc_pkg.sv]
// Shared constants, types and helper functions of the AABB tile collision resolver.
// Depends on nothing; aabbtc_cfg, aabbtc_div and the top level import it.

package aabbtc_pkg;

    // Map grid geometry.
    localparam int GRID_COLS = 32;
    localparam int GRID_ROWS = 32;
    localparam int CELLS     = GRID_COLS * GRID_ROWS;
    localparam int ADDR_W    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int COL_W     = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
    localparam int ROW_W     = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;

    // Quotients only matter up to the grid size, so the divider saturates at 2**Q_STEPS.
    localparam int GRID_MAX = (GRID_COLS > GRID_ROWS) ? GRID_COLS : GRID_ROWS;
    localparam int Q_STEPS  = (GRID_MAX > 1) ? $clog2(GRID_MAX) : 1;
    localparam int Q_W      = Q_STEPS + 1;
    localparam int STEP_W   = (Q_STEPS > 1) ? $clog2(Q_STEPS) : 1;
    localparam int RNG_W    = ((Q_W > 6) ? Q_W : 6) + 1;

    // Divider lanes: low and high edge on each axis.
    localparam int DVD_W     = 15;
    localparam int LANE_N    = 4;
    localparam int LANE_X_LO = 0;
    localparam int LANE_X_HI = 1;
    localparam int LANE_Y_LO = 2;
    localparam int LANE_Y_HI = 3;

    // Field widths.
    localparam int TS_W   = 7;
    localparam int PW_W   = 12;
    localparam int MAP_W  = 6;
    localparam int CODE_W = 8;
    localparam int POS_W  = 16;
    localparam int PASS_W = 6;

    // Configuration port.
    localparam int CFG_AW = 5;
    localparam int CFG_DW = 32;

    typedef logic [1:0] t_op;
    localparam t_op OP_WR_TILE = 2'd0;
    localparam t_op OP_WR_BOMB = 2'd1;
    localparam t_op OP_MOVE    = 2'd2;

    typedef logic [2:0] t_reg_idx;
    localparam t_reg_idx REG_TILE_SIZE   = 3'd0;
    localparam t_reg_idx REG_PLAY_WIDTH  = 3'd1;
    localparam t_reg_idx REG_PLAY_HEIGHT = 3'd2;
    localparam t_reg_idx REG_MAP_COLS    = 3'd3;
    localparam t_reg_idx REG_MAP_ROWS    = 3'd4;
    localparam t_reg_idx REG_WALL_CODE   = 3'd5;
    localparam t_reg_idx REG_BLOCK_CODE  = 3'd6;

    localparam logic [TS_W-1:0]   RST_TILE_SIZE   = 7'd16;
    localparam logic [PW_W-1:0]   RST_PLAY_WIDTH  = 12'd512;
    localparam logic [PW_W-1:0]   RST_PLAY_HEIGHT = 12'd512;
    localparam logic [MAP_W-1:0]  RST_MAP_COLS    = 6'd32;
    localparam logic [MAP_W-1:0]  RST_MAP_ROWS    = 6'd32;
    localparam logic [CODE_W-1:0] RST_WALL_CODE   = 8'd1;
    localparam logic [CODE_W-1:0] RST_BLOCK_CODE  = 8'd2;

    typedef struct packed {
        logic [TS_W-1:0]   tile_size;
        logic [PW_W-1:0]   play_width;
        logic [PW_W-1:0]   play_height;
        logic [MAP_W-1:0]  map_cols;
        logic [MAP_W-1:0]  map_rows;
        logic [CODE_W-1:0] wall_code;
        logic [CODE_W-1:0] block_code;
    } t_cfg;

    typedef logic [ADDR_W-1:0]                t_addr;
    typedef logic [LANE_N-1:0][DVD_W-1:0]     t_dvd_vec;
    typedef logic [LANE_N-1:0][Q_W-1:0]       t_quot_vec;

    // Linear address of a map cell, row major.
    function automatic t_addr f_cell_addr(input logic [ROW_W-1:0] row,
                                          input logic [COL_W-1:0] col);
        return t_addr'(32'(row) * GRID_COLS + 32'(col));
    endfunction

    // A tile size of zero behaves as one.
    function automatic logic [TS_W-1:0] f_tile_eff(input logic [TS_W-1:0] ts);
        return (ts == '0) ? TS_W'(1) : ts;
    endfunction

endpackage

[hw/rtl/aabbtc_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing; instantiated for the tile map and the bomb map.

module aabbtc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/aabbtc_cfg.sv]
// Configuration register file behind an APB-style port.
// Depends on aabbtc_pkg for register indexes, reset values and the t_cfg type.

module aabbtc_cfg
    import aabbtc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[CFG_AW-1:2];
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tile_size   <= RST_TILE_SIZE;
            r_cfg.play_width  <= RST_PLAY_WIDTH;
            r_cfg.play_height <= RST_PLAY_HEIGHT;
            r_cfg.map_cols    <= RST_MAP_COLS;
            r_cfg.map_rows    <= RST_MAP_ROWS;
            r_cfg.wall_code   <= RST_WALL_CODE;
            r_cfg.block_code  <= RST_BLOCK_CODE;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_TILE_SIZE:   r_cfg.tile_size   <= pwdata[TS_W-1:0];
                REG_PLAY_WIDTH:  r_cfg.play_width  <= pwdata[PW_W-1:0];
                REG_PLAY_HEIGHT: r_cfg.play_height <= pwdata[PW_W-1:0];
                REG_MAP_COLS:    r_cfg.map_cols    <= pwdata[MAP_W-1:0];
                REG_MAP_ROWS:    r_cfg.map_rows    <= pwdata[MAP_W-1:0];
                REG_WALL_CODE:   r_cfg.wall_code   <= pwdata[CODE_W-1:0];
                REG_BLOCK_CODE:  r_cfg.block_code  <= pwdata[CODE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_TILE_SIZE:   prdata = CFG_DW'(r_cfg.tile_size);
            REG_PLAY_WIDTH:  prdata = CFG_DW'(r_cfg.play_width);
            REG_PLAY_HEIGHT: prdata = CFG_DW'(r_cfg.play_height);
            REG_MAP_COLS:    prdata = CFG_DW'(r_cfg.map_cols);
            REG_MAP_ROWS:    prdata = CFG_DW'(r_cfg.map_rows);
            REG_WALL_CODE:   prdata = CFG_DW'(r_cfg.wall_code);
            REG_BLOCK_CODE:  prdata = CFG_DW'(r_cfg.block_code);
            default:         prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

[hw/rtl/aabbtc_div.sv]
// Four-lane restoring divider by the tile size, one quotient bit per cycle, saturating.
// Depends on aabbtc_pkg for lane count, quotient width and step count.

module aabbtc_div
    import aabbtc_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  t_dvd_vec        i_dvd,
    input  logic [TS_W-1:0] i_ts,
    output logic            o_done,
    output t_quot_vec       o_quot
);

    localparam int REM_W = DVD_W + 1;

    logic                          r_busy;
    logic                          r_done;
    logic [STEP_W-1:0]             r_step;
    logic [LANE_N-1:0][REM_W-1:0]  r_rem;
    logic [LANE_N-1:0]             r_sat;
    t_quot_vec                     r_quot;
    logic [TS_W-1:0]               r_ts;
    logic [LANE_N-1:0]             w_sat;
    logic [REM_W-1:0]              w_divs;

    // A dividend at or above ts << Q_STEPS has a quotient beyond any grid index.
    always_comb begin
        for (int l = 0; l < LANE_N; l++) begin
            w_sat[l] = (32'(i_dvd[l]) >= (32'(i_ts) << Q_STEPS));
        end
    end

    assign w_divs = REM_W'(r_ts) << r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(Q_STEPS - 1);
            end else if (r_busy) begin
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step - STEP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ts <= i_ts;
            for (int l = 0; l < LANE_N; l++) begin
                r_rem[l]  <= REM_W'(i_dvd[l]);
                r_sat[l]  <= w_sat[l];
                r_quot[l] <= w_sat[l] ? (Q_W'(1) << Q_STEPS) : '0;
            end
        end else if (r_busy) begin
            for (int l = 0; l < LANE_N; l++) begin
                if (!r_sat[l] && (r_rem[l] >= w_divs)) begin
                    r_rem[l]  <= r_rem[l] - w_divs;
                    r_quot[l] <= r_quot[l] | (Q_W'(1) << r_step);
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

[hw/rtl/aabb_tile_collision_resolve.sv]
// Top level of the AABB tile collision resolver: stream ports, sequencer and map memories.
// Depends on aabbtc_pkg, aabbtc_cfg, aabbtc_div and aabbtc_ram.
//
// Sequence: a write transfer gives no result. A move steps through the position, clamp,
// divide and range states, then a read and a test of each scanned cell, a push on a hit
// and the done state before its result is registered; the four-lane divider by the tile
// size and the read-then-test of each scanned cell in the tile and bomb memories set its latency.
// Throughput: one move at a time; a new item is taken as soon as the previous move has
// handed its result to the output register, even while that result waits for m_axis_tready.
// Reset: synchronous, active low. After reset the bomb map is swept to zero, one entry a
// cycle, and s_axis_tready stays low during that sweep.

module aabb_tile_collision_resolve
    import aabbtc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Input stream.
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // From bit 0: cell_col[4:0], cell_row[9:5], cell_value[17:10], pos_x[33:18],
    // pos_y[49:34], delta_x[65:50], delta_y[81:66], pass_col[87:82], pass_row[93:88],
    // use_bombs[94], zero[95].
    input  logic [95:0]       s_axis_tdata,
    // From bit 0: operation[1:0].
    input  logic [1:0]        s_axis_tuser,
    // Result stream.
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // From bit 0: new_x[15:0], new_y[31:16].
    output logic [31:0]       m_axis_tdata,
    // Configuration port.
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready
);

    // Sequencer states.
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_POS   = 4'd1;
    localparam logic [3:0] S_CLAMP = 4'd2;
    localparam logic [3:0] S_DIV   = 4'd3;
    localparam logic [3:0] S_RANGE = 4'd4;
    localparam logic [3:0] S_RD    = 4'd5;
    localparam logic [3:0] S_EVAL  = 4'd6;
    localparam logic [3:0] S_PUSH  = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    // Per-axis outcome of the play-area clamp.
    typedef struct packed {
        logic signed [POS_W-1:0] pos;
        logic [DVD_W-1:0]        lo_dvd;
        logic [DVD_W-1:0]        hi_dvd;
        logic                    hi_empty;
    } t_axis;

    // Clamp one axis to [0, play] and prepare the low and high edge dividends. A negative low edge
    // maps to cell 0; a high edge minus one in (-ts, 0) truncates to cell 0 as well, and at
    // or below -ts the axis range is empty.
    function automatic t_axis f_axis(input logic signed [POS_W-1:0] n,
                                     input logic [TS_W-1:0] ts,
                                     input logic [PW_W-1:0] pw);
        logic signed [POS_W-1:0] lo;
        logic signed [POS_W-1:0] hi;
        logic signed [POS_W-1:0] ts_s;
        logic signed [POS_W-1:0] pw_s;
        logic signed [POS_W:0]   hm1;
        logic signed [POS_W:0]   ts_w;
        t_axis                   a;
        ts_s = $signed({9'b0, ts});
        pw_s = $signed({4'b0, pw});
        ts_w = $signed({10'b0, ts});
        lo   = n;
        hi   = n + ts_s;
        if (lo < 0) begin
            lo = '0;
            hi = ts_s;
        end
        if (hi > pw_s) begin
            lo = pw_s - ts_s;
            hi = pw_s;
        end
        hm1        = $signed({hi[POS_W-1], hi}) - 17'sd1;
        a.pos      = lo;
        a.lo_dvd   = lo[POS_W-1] ? '0 : lo[DVD_W-1:0];
        a.hi_dvd   = hm1[POS_W] ? '0 : hm1[DVD_W-1:0];
        a.hi_empty = (hm1 + ts_w) <= 17'sd0;
        return a;
    endfunction

    t_cfg                   w_cfg;
    logic [TS_W-1:0]        w_ts;
    logic                   w_in_acc;
    t_op                    w_op;
    logic [4:0]             w_in_col;
    logic [4:0]             w_in_row;
    logic [CODE_W-1:0]      w_in_val;
    logic                   w_in_grid;
    t_addr                  w_wr_addr;

    logic [3:0]             r_state;
    logic [3:0]             n_state;
    logic                   r_clr_busy;
    t_addr                  r_clr_addr;

    // Latched move fields.
    logic signed [POS_W-1:0] r_pos_x;
    logic signed [POS_W-1:0] r_pos_y;
    logic signed [POS_W-1:0] r_dx;
    logic signed [POS_W-1:0] r_dy;
    logic [PASS_W-1:0]       r_pass_col;
    logic [PASS_W-1:0]       r_pass_row;
    logic                    r_use_bombs;

    // Working position and scan range.
    logic signed [POS_W-1:0] r_nx;
    logic signed [POS_W-1:0] r_ny;
    logic                    r_x_empty;
    logic                    r_y_empty;
    logic [COL_W-1:0]        r_c0;
    logic [COL_W-1:0]        r_c1;
    logic [ROW_W-1:0]        r_r1;
    logic [COL_W-1:0]        r_col;
    logic [ROW_W-1:0]        r_row;
    logic [COL_W-1:0]        r_hit_col;
    logic [ROW_W-1:0]        r_hit_row;

    logic                    r_out_valid;
    logic [31:0]             r_out_data;

    t_axis                   w_ax;
    t_axis                   w_ay;
    t_dvd_vec                w_dvd;
    logic                    w_div_start;
    logic                    w_div_done;
    t_quot_vec               w_quot;

    logic [RNG_W-1:0]        w_mc;
    logic [RNG_W-1:0]        w_mr;
    logic [RNG_W-1:0]        w_c0;
    logic [RNG_W-1:0]        w_c1;
    logic [RNG_W-1:0]        w_r0;
    logic [RNG_W-1:0]        w_r1;
    logic                    w_rng_empty;

    logic [CODE_W-1:0]       w_tile_q;
    logic                    w_bomb_q;
    logic                    w_bomb_we;
    t_addr                   w_bomb_waddr;
    logic                    w_tile_we;
    t_addr                   w_rd_addr;
    logic                    w_pass_hit;
    logic                    w_solid;
    logic                    w_out_free;

    logic [POS_W-1:0]        w_prod_x;
    logic [POS_W-1:0]        w_prod_y;

    aabbtc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_ts = f_tile_eff(w_cfg.tile_size);

    // Input transfer and map writes. Writes land at the transfer edge; a move never runs
    // at the same time, so a scan always sees every earlier write.
    assign s_axis_tready = (r_state == S_IDLE) && !r_clr_busy;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_op          = s_axis_tuser;
    assign w_in_col      = s_axis_tdata[4:0];
    assign w_in_row      = s_axis_tdata[9:5];
    assign w_in_val      = s_axis_tdata[17:10];
    assign w_in_grid     = (32'(w_in_col) < GRID_COLS) && (32'(w_in_row) < GRID_ROWS);
    assign w_wr_addr     = f_cell_addr(ROW_W'(w_in_row), COL_W'(w_in_col));

    assign w_tile_we    = w_in_acc && (w_op == OP_WR_TILE) && w_in_grid;
    assign w_bomb_we    = r_clr_busy || (w_in_acc && (w_op == OP_WR_BOMB) && w_in_grid);
    assign w_bomb_waddr = r_clr_busy ? r_clr_addr : w_wr_addr;
    assign w_rd_addr    = f_cell_addr(r_row, r_col);

    aabbtc_ram #(
        .WIDTH (CODE_W),
        .DEPTH (CELLS)
    ) u_tile_ram (
        .i_clk   (i_clk),
        .i_we    (w_tile_we),
        .i_waddr (w_wr_addr),
        .i_wdata (w_in_val),
        .i_raddr (w_rd_addr),
        .o_rdata (w_tile_q)
    );

    aabbtc_ram #(
        .WIDTH (1),
        .DEPTH (CELLS)
    ) u_bomb_ram (
        .i_clk   (i_clk),
        .i_we    (w_bomb_we),
        .i_waddr (w_bomb_waddr),
        .i_wdata (r_clr_busy ? 1'b0 : w_in_val[0]),
        .i_raddr (w_rd_addr),
        .o_rdata (w_bomb_q)
    );

    // Clamp stage feeds the divider directly.
    assign w_ax = f_axis(r_nx, w_ts, w_cfg.play_width);
    assign w_ay = f_axis(r_ny, w_ts, w_cfg.play_height);

    always_comb begin
        w_dvd            = '0;
        w_dvd[LANE_X_LO] = w_ax.lo_dvd;
        w_dvd[LANE_X_HI] = w_ax.hi_dvd;
        w_dvd[LANE_Y_LO] = w_ay.lo_dvd;
        w_dvd[LANE_Y_HI] = w_ay.hi_dvd;
    end

    assign w_div_start = (r_state == S_CLAMP);

    aabbtc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_dvd   (w_dvd),
        .i_ts    (w_ts),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // Scan range: clamp the high cells to the map in use, which is itself capped at the grid.
    assign w_mc = (32'(w_cfg.map_cols) > GRID_COLS) ? RNG_W'(GRID_COLS)
                                                    : RNG_W'(w_cfg.map_cols);
    assign w_mr = (32'(w_cfg.map_rows) > GRID_ROWS) ? RNG_W'(GRID_ROWS)
                                                    : RNG_W'(w_cfg.map_rows);
    assign w_c0 = RNG_W'(w_quot[LANE_X_LO]);
    assign w_r0 = RNG_W'(w_quot[LANE_Y_LO]);
    assign w_c1 = (RNG_W'(w_quot[LANE_X_HI]) >= w_mc) ? (w_mc - RNG_W'(1))
                                                      : RNG_W'(w_quot[LANE_X_HI]);
    assign w_r1 = (RNG_W'(w_quot[LANE_Y_HI]) >= w_mr) ? (w_mr - RNG_W'(1))
                                                      : RNG_W'(w_quot[LANE_Y_HI]);
    assign w_rng_empty = r_x_empty || r_y_empty || (w_mc == '0) || (w_mr == '0) ||
                         (w_c0 > w_c1) || (w_r0 > w_r1);

    // Cell test on the registered memory data. The pass-through cell is matched only
    // when its index is not negative.
    assign w_pass_hit = !r_pass_col[PASS_W-1] && !r_pass_row[PASS_W-1] &&
                        (7'(r_col) == 7'(r_pass_col[PASS_W-2:0])) &&
                        (7'(r_row) == 7'(r_pass_row[PASS_W-2:0]));
    assign w_solid = (w_tile_q == w_cfg.wall_code) || (w_tile_q == w_cfg.block_code) ||
                     (r_use_bombs && w_bomb_q && !w_pass_hit);

    // Push against the hit tile: cell * ts, then one tile back or forward.
    assign w_prod_x = POS_W'(r_hit_col) * POS_W'(w_ts);
    assign w_prod_y = POS_W'(r_hit_row) * POS_W'(w_ts);

    assign w_out_free = !r_out_valid || m_axis_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_in_acc && (w_op == OP_MOVE)) n_state = S_POS;
            S_POS:   n_state = S_CLAMP;
            S_CLAMP: n_state = S_DIV;
            S_DIV:   if (w_div_done) n_state = S_RANGE;
            S_RANGE: n_state = w_rng_empty ? S_DONE : S_RD;
            S_RD:    n_state = S_EVAL;
            S_EVAL: begin
                if (w_solid) begin
                    n_state = S_PUSH;
                end else if ((r_col == r_c1) && (r_row == r_r1)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_RD;
                end
            end
            S_PUSH:  n_state = S_DONE;
            S_DONE:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + t_addr'(1);
                if (r_clr_addr == t_addr'(CELLS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_pos_x     <= $signed(s_axis_tdata[33:18]);
            r_pos_y     <= $signed(s_axis_tdata[49:34]);
            r_dx        <= $signed(s_axis_tdata[65:50]);
            r_dy        <= $signed(s_axis_tdata[81:66]);
            r_pass_col  <= s_axis_tdata[87:82];
            r_pass_row  <= s_axis_tdata[93:88];
            r_use_bombs <= s_axis_tdata[94];
        end
        unique case (r_state)
            S_POS: begin
                r_nx <= r_pos_x + r_dx;
                r_ny <= r_pos_y + r_dy;
            end
            S_CLAMP: begin
                r_nx      <= w_ax.pos;
                r_ny      <= w_ay.pos;
                r_x_empty <= w_ax.hi_empty;
                r_y_empty <= w_ay.hi_empty;
            end
            S_RANGE: begin
                r_c0  <= COL_W'(w_c0);
                r_c1  <= COL_W'(w_c1);
                r_r1  <= ROW_W'(w_r1);
                r_col <= COL_W'(w_c0);
                r_row <= ROW_W'(w_r0);
            end
            S_EVAL: begin
                if (w_solid) begin
                    r_hit_col <= r_col;
                    r_hit_row <= r_row;
                end else if (r_col == r_c1) begin
                    r_col <= r_c0;
                    r_row <= r_row + ROW_W'(1);
                end else begin
                    r_col <= r_col + COL_W'(1);
                end
            end
            S_PUSH: begin
                if (r_dx > 0) begin
                    r_nx <= $signed(w_prod_x - POS_W'(w_ts));
                end else if (r_dx < 0) begin
                    r_nx <= $signed(w_prod_x + POS_W'(w_ts));
                end
                if (r_dy > 0) begin
                    r_ny <= $signed(w_prod_y - POS_W'(w_ts));
                end else if (r_dy < 0) begin
                    r_ny <= $signed(w_prod_y + POS_W'(w_ts));
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_out_data <= {r_ny, r_nx};
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // A cell test always follows the read of that cell.
    a_eval_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |-> ($past(r_state) == S_RD))
        else $error("cell test without a preceding memory read");

    // Every scanned cell lies inside the clamped range.
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> ((r_col >= r_c0) && (r_col <= r_c1) && (r_row <= r_r1)))
        else $error("scan address left the clamped range");

    // The divider reports completion only while the sequencer waits for it.
    a_div_done_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the wait state");

    // A finished move is shown on the result port at the next edge.
    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && w_out_free) |=> (m_axis_tvalid && (r_state == S_IDLE)))
        else $error("finished move not presented on the result port");

endmodule
